>>> rtl/osu_pkg.sv
// ============================================================================
// osu_pkg: shared types and constants for the oversampled soft UART
// Command codes, frame constants and the per-word status record.
// ============================================================================
`default_nettype none

package osu_pkg;

    // Command codes carried with each input word
    typedef enum logic [1:0] {
        CMD_TICK  = 2'd0,
        CMD_SEND  = 2'd1,
        CMD_READ  = 2'd2,
        CMD_FLUSH = 2'd3
    } t_cmd;

    // Frame timing at three ticks per bit
    localparam logic [1:0] TICKS_PER_BIT      = 2'd3;
    localparam logic [2:0] RX_TICKS_PER_BIT   = 3'd3;
    localparam logic [2:0] FIRST_SAMPLE_DELAY = 3'd4;
    localparam logic [3:0] TX_FRAME_BITS      = 4'd10;
    localparam logic [3:0] RX_DATA_BITS       = 4'd8;
    localparam logic [9:0] STOP_MARK          = 10'h200;

    // Status of one word after its command is applied
    typedef struct packed {
        logic tx_pin;
        logic tx_busy;
        logic send_accepted;
        logic rd_valid;
        logic data_available;
    } t_status;

endpackage

`default_nettype wire

>>> rtl/osu_ram.sv
// ============================================================================
// osu_ram: generic simple dual-port RAM
// One write port, one read port with a registered read and read enable.
// ============================================================================
`default_nettype none

module osu_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 32
) (
    input  wire                       i_clk,
    input  wire                       i_we,
    input  wire [$clog2(DEPTH)-1:0]   i_waddr,
    input  wire [WIDTH-1:0]           i_wdata,
    input  wire                       i_re,
    input  wire [$clog2(DEPTH)-1:0]   i_raddr,
    output logic [WIDTH-1:0]          o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    // write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // registered read, held while not enabled
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            o_rdata <= r_mem[i_raddr];
        end
    end

endmodule

`default_nettype wire

>>> rtl/osu_engine.sv
// ============================================================================
// osu_engine: UART transmit/receive state and FIFO index control
// Applies one command per accepted word and drives the FIFO RAM ports.
// ============================================================================
`default_nettype none

module osu_engine #(
    parameter int FIFO_DEPTH = 32
) (
    input  wire                           i_clk,
    input  wire                           i_rst_n,
    input  wire                           i_accept,
    input  osu_pkg::t_cmd                 i_cmd,
    input  wire                           i_rx_pin,
    input  wire [7:0]                     i_tx_byte,
    input  wire                           i_rx_enable,
    output logic                          o_ram_we,
    output logic [$clog2(FIFO_DEPTH)-1:0] o_ram_waddr,
    output logic [7:0]                    o_ram_wdata,
    output logic                          o_ram_re,
    output logic [$clog2(FIFO_DEPTH)-1:0] o_ram_raddr,
    output osu_pkg::t_status              o_status
);
    import osu_pkg::*;

    localparam int IW = $clog2(FIFO_DEPTH);
    localparam logic [IW-1:0] LAST_IDX = IW'(FIFO_DEPTH - 1);

    logic          r_tx_active, n_tx_active;
    logic [1:0]    r_tx_tick,   n_tx_tick;
    logic [3:0]    r_tx_bits,   n_tx_bits;
    logic [9:0]    r_tx_shift,  n_tx_shift;
    logic          r_tx_level,  n_tx_level;
    logic          r_rx_frame,  n_rx_frame;
    logic          r_rx_stop,   n_rx_stop;
    logic [2:0]    r_rx_tick,   n_rx_tick;
    logic [3:0]    r_rx_bits,   n_rx_bits;
    logic [7:0]    r_rx_shift,  n_rx_shift;
    logic [7:0]    r_rx_mask,   n_rx_mask;
    logic [IW-1:0] r_wr_idx,    n_wr_idx;
    logic [IW-1:0] r_rd_idx,    n_rd_idx;
    logic          w_push;
    logic          w_pop;
    logic          w_sent;
    logic [1:0]    w_tx_dec;
    logic [2:0]    w_rx_dec;

    assign w_tx_dec = r_tx_tick - 2'd1;
    assign w_rx_dec = r_rx_tick - 3'd1;

    // next-state for one command
    always_comb begin
        n_tx_active = r_tx_active;
        n_tx_tick   = r_tx_tick;
        n_tx_bits   = r_tx_bits;
        n_tx_shift  = r_tx_shift;
        n_tx_level  = r_tx_level;
        n_rx_frame  = r_rx_frame;
        n_rx_stop   = r_rx_stop;
        n_rx_tick   = r_rx_tick;
        n_rx_bits   = r_rx_bits;
        n_rx_shift  = r_rx_shift;
        n_rx_mask   = r_rx_mask;
        n_wr_idx    = r_wr_idx;
        n_rd_idx    = r_rd_idx;
        w_push      = 1'b0;
        w_pop       = 1'b0;
        w_sent      = 1'b0;
        if (i_accept) begin
            case (i_cmd)
                CMD_TICK: begin
                    // transmitter: one bit every three ticks
                    if (r_tx_active) begin
                        n_tx_tick = w_tx_dec;
                        if (w_tx_dec == 2'd0) begin
                            n_tx_level = r_tx_shift[0];
                            n_tx_shift = {1'b0, r_tx_shift[9:1]};
                            n_tx_tick  = TICKS_PER_BIT;
                            n_tx_bits  = r_tx_bits - 4'd1;
                            if (r_tx_bits == 4'd1) begin
                                n_tx_active = 1'b0;
                            end
                        end
                    end
                    // receiver
                    if (i_rx_enable) begin
                        if (r_rx_stop) begin
                            n_rx_tick = w_rx_dec;
                            if (w_rx_dec == 3'd0) begin
                                n_rx_stop  = 1'b0;
                                n_rx_frame = 1'b0;
                                w_push     = 1'b1;
                                n_wr_idx   = (r_wr_idx == LAST_IDX) ? '0 : r_wr_idx + 1'b1;
                            end
                        end else if (!r_rx_frame) begin
                            if (!i_rx_pin) begin
                                n_rx_frame = 1'b1;
                                n_rx_shift = 8'd0;
                                n_rx_tick  = FIRST_SAMPLE_DELAY;
                                n_rx_bits  = RX_DATA_BITS;
                                n_rx_mask  = 8'd1;
                            end
                        end else begin
                            n_rx_tick = w_rx_dec;
                            if (w_rx_dec == 3'd0) begin
                                n_rx_tick = RX_TICKS_PER_BIT;
                                if (i_rx_pin) begin
                                    n_rx_shift = r_rx_shift | r_rx_mask;
                                end
                                n_rx_mask = {r_rx_mask[6:0], 1'b0};
                                n_rx_bits = r_rx_bits - 4'd1;
                                if (r_rx_bits == 4'd1) begin
                                    n_rx_stop = 1'b1;
                                end
                            end
                        end
                    end
                end
                CMD_SEND: begin
                    // rejected while a frame is going out
                    if (!r_tx_active) begin
                        n_tx_tick   = TICKS_PER_BIT;
                        n_tx_bits   = TX_FRAME_BITS;
                        n_tx_shift  = {1'b0, i_tx_byte, 1'b0} | STOP_MARK;
                        n_tx_active = 1'b1;
                        w_sent      = 1'b1;
                    end
                end
                CMD_READ: begin
                    if (r_rd_idx != r_wr_idx) begin
                        w_pop    = 1'b1;
                        n_rd_idx = (r_rd_idx == LAST_IDX) ? '0 : r_rd_idx + 1'b1;
                    end
                end
                CMD_FLUSH: begin
                    n_wr_idx = '0;
                    n_rd_idx = '0;
                end
                default: begin
                    n_wr_idx = r_wr_idx;
                end
            endcase
        end
    end

    // state registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tx_active <= 1'b0;
            r_tx_tick   <= 2'd0;
            r_tx_bits   <= 4'd0;
            r_tx_shift  <= 10'd0;
            r_tx_level  <= 1'b1;
            r_rx_frame  <= 1'b0;
            r_rx_stop   <= 1'b0;
            r_rx_tick   <= 3'd0;
            r_rx_bits   <= 4'd0;
            r_rx_shift  <= 8'd0;
            r_rx_mask   <= 8'd0;
            r_wr_idx    <= '0;
            r_rd_idx    <= '0;
        end else begin
            r_tx_active <= n_tx_active;
            r_tx_tick   <= n_tx_tick;
            r_tx_bits   <= n_tx_bits;
            r_tx_shift  <= n_tx_shift;
            r_tx_level  <= n_tx_level;
            r_rx_frame  <= n_rx_frame;
            r_rx_stop   <= n_rx_stop;
            r_rx_tick   <= n_rx_tick;
            r_rx_bits   <= n_rx_bits;
            r_rx_shift  <= n_rx_shift;
            r_rx_mask   <= n_rx_mask;
            r_wr_idx    <= n_wr_idx;
            r_rd_idx    <= n_rd_idx;
        end
    end

    // FIFO RAM ports: push the finished byte, read at the current head
    assign o_ram_we    = w_push;
    assign o_ram_waddr = r_wr_idx;
    assign o_ram_wdata = r_rx_shift;
    assign o_ram_re    = w_pop;
    assign o_ram_raddr = r_rd_idx;

    // status seen after the command
    assign o_status.tx_pin         = n_tx_level;
    assign o_status.tx_busy        = n_tx_active;
    assign o_status.send_accepted  = w_sent;
    assign o_status.rd_valid       = w_pop;
    assign o_status.data_available = (n_rd_idx != n_wr_idx);

    // a finished frame leaves the line at the stop level
    a_tx_ends_high: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $fell(r_tx_active) |-> r_tx_level)
        else $error("tx line not high after frame");

    // a flush clears both indices
    a_flush_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_accept && i_cmd == CMD_FLUSH) |=> (r_wr_idx == '0 && r_rd_idx == '0))
        else $error("flush did not clear indices");

    // a read from an empty FIFO never moves the read index
    a_no_pop_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_pop |-> (r_rd_idx != r_wr_idx))
        else $error("pop from empty FIFO");

endmodule

`default_nettype wire

>>> rtl/oversampled_soft_uart.sv
// ============================================================================
// oversampled_soft_uart: 8N1 UART port with 3x tick oversampling
// Command stream in, one status word out per command; receive FIFO in RAM.
// ============================================================================
// Pipeline: an accepted word is registered in stage 1 together with the FIFO RAM
// read data, then in the output register of stage 2, which drives the result.
// Throughput: one command per cycle; the FIFO RAM read and the status stage
// overlap. The two output stages hold up to two words while the output
// stalls; after that, input waits until the output drains.
// Reset: synchronous, active low; clears all UART and index state, sets the
// transmit line high and rx_enable to 1. FIFO contents are left uncleared.
`default_nettype none

module oversampled_soft_uart #(
    parameter int FIFO_DEPTH = 32
) (
    input  wire         i_clk,
    input  wire         i_rst_n,
    // command stream
    input  wire         s_axis_tvalid,
    output logic        s_axis_tready,
    input  wire  [15:0] s_axis_tdata,   // [0] rx_pin, [8:1] tx_byte, [15:9] zero
    input  wire  [1:0]  s_axis_tuser,   // [1:0] cmd
    // result stream
    output logic        m_axis_tvalid,
    input  wire         m_axis_tready,
    output logic [15:0] m_axis_tdata,   // [0] tx_pin, [1] tx_busy, [2] send_accepted,
                                        // [10:3] rx_byte, [11] rx_byte_valid,
                                        // [12] data_available, [15:13] zero
    // configuration: rx_enable
    input  wire         i_cfg_valid,
    output logic        o_cfg_ready,
    input  wire  [0:0]  i_cfg_data
);
    import osu_pkg::*;

    localparam int IW = $clog2(FIFO_DEPTH);

    logic          r_rx_enable;
    logic          w_accept;
    logic          w_s1_move;
    logic          ram_we;
    logic [IW-1:0] ram_waddr;
    logic [7:0]    ram_wdata;
    logic          ram_re;
    logic [IW-1:0] ram_raddr;
    logic [7:0]    ram_rdata;
    t_status       w_status;
    logic          r_s1_valid;
    t_status       r_s1_status;
    logic          r_s2_valid;
    logic [15:0]   r_s2_data;
    logic [7:0]    w_rx_byte;

    // configuration register
    assign o_cfg_ready = 1'b1;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rx_enable <= 1'b1;
        end else if (i_cfg_valid) begin
            r_rx_enable <= i_cfg_data[0];
        end
    end

    // handshake: stage 1 waits on the RAM read, stage 2 drives the port
    assign w_s1_move     = r_s1_valid && (!r_s2_valid || m_axis_tready);
    assign s_axis_tready = !r_s1_valid || w_s1_move;
    assign w_accept      = s_axis_tvalid && s_axis_tready;

    osu_engine #(
        .FIFO_DEPTH (FIFO_DEPTH)
    ) u_engine (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_accept    (w_accept),
        .i_cmd       (t_cmd'(s_axis_tuser)),
        .i_rx_pin    (s_axis_tdata[0]),
        .i_tx_byte   (s_axis_tdata[8:1]),
        .i_rx_enable (r_rx_enable),
        .o_ram_we    (ram_we),
        .o_ram_waddr (ram_waddr),
        .o_ram_wdata (ram_wdata),
        .o_ram_re    (ram_re),
        .o_ram_raddr (ram_raddr),
        .o_status    (w_status)
    );

    osu_ram #(
        .WIDTH (8),
        .DEPTH (FIFO_DEPTH)
    ) u_fifo_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_re    (ram_re),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    // stage 1: status is registered alongside the registered RAM read data
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (w_accept) begin
            r_s1_valid <= 1'b1;
        end else if (w_s1_move) begin
            r_s1_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_s1_status <= w_status;
        end
    end

    assign w_rx_byte = r_s1_status.rd_valid ? ram_rdata : 8'd0;

    // stage 2: output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s2_valid <= 1'b0;
        end else if (w_s1_move) begin
            r_s2_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_s2_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_s1_move) begin
            r_s2_data <= {3'b000,
                          r_s1_status.data_available,
                          r_s1_status.rd_valid,
                          w_rx_byte,
                          r_s1_status.send_accepted,
                          r_s1_status.tx_busy,
                          r_s1_status.tx_pin};
        end
    end

    assign m_axis_tvalid = r_s2_valid;
    assign m_axis_tdata  = r_s2_data;

    // input is held back only while stage 1 is occupied and cannot drain
    a_ready_when_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !s_axis_tready |-> (r_s1_valid && r_s2_valid && !m_axis_tready))
        else $error("input stalled with free stage");

    // a byte without its valid flag is always zero
    a_byte_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && !m_axis_tdata[11]) |-> (m_axis_tdata[10:3] == 8'd0))
        else $error("rx byte set without valid");

    // an accepted send always reports a busy transmitter
    a_send_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && m_axis_tdata[2]) |-> m_axis_tdata[1])
        else $error("send accepted but not busy");

endmodule

`default_nettype wire

>>> dv/oversampled_soft_uart_test.sv
`timescale 1ns / 100ps
// ============================================================================
// oversampled_soft_uart_test: self-checking bench for the 3x soft UART port
// Drives command words (ticks, sends, reads, flushes) with random gaps and
// shapes the tick stream into 8N1 receive frames, some of them damaged.
// A shadow UART computes the status word due for every accepted command and
// each result word is checked against it field by field. rx_enable is moved
// between phases while the block is idle.
// ============================================================================

module oversampled_soft_uart_test;

    import osu_pkg::*;

    localparam int RX_FIFO_WORDS = 32;

    // Status word fields, lowest bit last
    typedef struct packed {
        logic       data_available;
        logic       rx_byte_valid;
        logic [7:0] rx_byte;
        logic       send_accepted;
        logic       tx_busy;
        logic       tx_pin;
    } uart_status_t;

    // One row of the directed table; want is used only when typed is set
    typedef struct packed {
        t_cmd         cmd;
        logic         pin;
        logic [7:0]   data;
        logic         typed;
        uart_status_t want;
    } dir_row_t;

    localparam uart_status_t ST_IDLE      = '{1'b0, 1'b0, 8'h00, 1'b0, 1'b0, 1'b1};
    localparam uart_status_t ST_SEND_OK   = '{1'b0, 1'b0, 8'h00, 1'b1, 1'b1, 1'b1};
    localparam uart_status_t ST_SEND_BUSY = '{1'b0, 1'b0, 8'h00, 1'b0, 1'b1, 1'b1};

    localparam int DIR_ROWS = 20;
    localparam dir_row_t DIRECTED [0:DIR_ROWS-1] = '{
        '{CMD_READ,  1'b0, 8'h00, 1'b1, ST_IDLE},      // empty read after reset
        '{CMD_FLUSH, 1'b1, 8'hFF, 1'b1, ST_IDLE},
        '{CMD_TICK,  1'b1, 8'h00, 1'b1, ST_IDLE},      // line idle, nothing starts
        '{CMD_SEND,  1'b0, 8'hFF, 1'b1, ST_SEND_OK},
        '{CMD_SEND,  1'b1, 8'h00, 1'b1, ST_SEND_BUSY}, // send while busy
        '{CMD_READ,  1'b1, 8'hFF, 1'b1, ST_SEND_BUSY}, // empty read while busy
        '{CMD_TICK,  1'b0, 8'h00, 1'b0, ST_IDLE},      // start bit seen
        '{CMD_TICK,  1'b0, 8'hFF, 1'b0, ST_IDLE},
        '{CMD_TICK,  1'b0, 8'h55, 1'b0, ST_IDLE},      // tx start bit goes out
        '{CMD_TICK,  1'b1, 8'hAA, 1'b0, ST_IDLE},
        '{CMD_FLUSH, 1'b0, 8'h00, 1'b0, ST_IDLE},      // flush mid receive frame
        '{CMD_TICK,  1'b1, 8'h01, 1'b0, ST_IDLE},
        '{CMD_SEND,  1'b1, 8'h80, 1'b0, ST_IDLE},
        '{CMD_TICK,  1'b0, 8'h7F, 1'b0, ST_IDLE},
        '{CMD_TICK,  1'b1, 8'hFE, 1'b0, ST_IDLE},
        '{CMD_READ,  1'b0, 8'h00, 1'b0, ST_IDLE},
        '{CMD_TICK,  1'b1, 8'h00, 1'b0, ST_IDLE},
        '{CMD_TICK,  1'b1, 8'hFF, 1'b0, ST_IDLE},
        '{CMD_TICK,  1'b1, 8'h00, 1'b0, ST_IDLE},
        '{CMD_FLUSH, 1'b1, 8'hFF, 1'b0, ST_IDLE}
    };

    logic        i_clk = 1'b0;
    logic        i_rst_n;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [15:0] s_axis_tdata;
    logic [1:0]  s_axis_tuser;
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [15:0] m_axis_tdata;
    logic        i_cfg_valid;
    logic        o_cfg_ready;
    logic [0:0]  i_cfg_data;

    oversampled_soft_uart #(.FIFO_DEPTH(RX_FIFO_WORDS)) uut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_data    (i_cfg_data)
    );

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    // Shadow UART state
    logic       rx_enabled;
    logic       tx_run;
    logic [1:0] tx_phase;
    logic [3:0] tx_left;
    logic [9:0] tx_sr;
    logic       tx_line;
    logic       rx_run;
    logic       rx_stop_wait;
    logic [2:0] rx_phase;
    logic [3:0] rx_left;
    logic [7:0] rx_sr;
    logic [7:0] rx_mask;
    logic [7:0] rx_fifo [RX_FIFO_WORDS];
    logic [4:0] wr_ptr;
    logic [4:0] rd_ptr;

    uart_status_t status_due [$];
    int  fail_count   = 0;
    int  results_seen = 0;
    bit  no_gap       = 1'b0;

    // Apply one command to the shadow UART and return the status it leaves
    function automatic uart_status_t uart_status_after(input t_cmd c, input logic pin,
                                                       input logic [7:0] b);
        uart_status_t st;
        st = '0;
        case (c)
            CMD_TICK: begin
                // transmitter: one bit per three ticks
                if (tx_run) begin
                    tx_phase = tx_phase - 2'd1;
                    if (tx_phase == 2'd0) begin
                        tx_line  = tx_sr[0];
                        tx_sr    = tx_sr >> 1;
                        tx_phase = TICKS_PER_BIT;
                        tx_left  = tx_left - 4'd1;
                        if (tx_left == 4'd0)
                            tx_run = 1'b0;
                    end
                end
                // receiver: start hunt, data samples, stop wait
                if (rx_enabled) begin
                    if (rx_stop_wait) begin
                        rx_phase = rx_phase - 3'd1;
                        if (rx_phase == 3'd0) begin
                            rx_stop_wait    = 1'b0;
                            rx_run          = 1'b0;
                            rx_fifo[wr_ptr] = rx_sr;
                            wr_ptr          = wr_ptr + 5'd1;
                        end
                    end else if (!rx_run) begin
                        if (!pin) begin
                            rx_run   = 1'b1;
                            rx_sr    = 8'h00;
                            rx_phase = FIRST_SAMPLE_DELAY;
                            rx_left  = RX_DATA_BITS;
                            rx_mask  = 8'h01;
                        end
                    end else begin
                        rx_phase = rx_phase - 3'd1;
                        if (rx_phase == 3'd0) begin
                            rx_phase = RX_TICKS_PER_BIT;
                            if (pin)
                                rx_sr = rx_sr | rx_mask;
                            rx_mask = rx_mask << 1;
                            rx_left = rx_left - 4'd1;
                            if (rx_left == 4'd0)
                                rx_stop_wait = 1'b1;
                        end
                    end
                end
            end
            CMD_SEND: begin
                if (!tx_run) begin
                    tx_phase         = TICKS_PER_BIT;
                    tx_left          = TX_FRAME_BITS;
                    tx_sr            = STOP_MARK | {1'b0, b, 1'b0};
                    tx_run           = 1'b1;
                    st.send_accepted = 1'b1;
                end
            end
            CMD_READ: begin
                if (rd_ptr != wr_ptr) begin
                    st.rx_byte       = rx_fifo[rd_ptr];
                    st.rx_byte_valid = 1'b1;
                    rd_ptr           = rd_ptr + 5'd1;
                end
            end
            default: begin
                wr_ptr = '0;
                rd_ptr = '0;
            end
        endcase
        st.tx_pin         = tx_line;
        st.tx_busy        = tx_run;
        st.data_available = (rd_ptr != wr_ptr);
        return st;
    endfunction

    task automatic note_failure(input string msg);
        if (fail_count < 40)
            $display("[%0t] ERROR: %s", $realtime, msg);
        fail_count++;
    endtask

    // Mostly short gaps, a few long ones
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        else if (r < 90)
            return $urandom_range(1, 3);
        return $urandom_range(8, 30);
    endfunction

    // Offer one command word, predict its status once accepted
    task automatic put_word(input t_cmd c, input logic pin, input logic [7:0] b,
                            input logic typed = 1'b0, input uart_status_t want = '0);
        int gap;
        uart_status_t st;
        gap = no_gap ? 0 : pick_gap();
        if (gap > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= c;
        s_axis_tdata  <= {7'd0, b, pin};
        @(posedge i_clk);
        while (!s_axis_tready)
            @(posedge i_clk);
        st = uart_status_after(c, pin, b);
        status_due.push_back(typed ? want : st);
    endtask

    // Register write while the block is idle
    task automatic write_rx_enable(input logic v);
        s_axis_tvalid <= 1'b0;
        while (status_due.size() != 0)
            @(posedge i_clk);
        repeat (4) @(posedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= v;
        @(posedge i_clk);
        while (!o_cfg_ready)
            @(posedge i_clk);
        i_cfg_valid <= 1'b0;
        rx_enabled = v;
    endtask

    // A host access between ticks: read, send or flush
    task automatic host_word(input bit reads_ok, input bit flush_ok);
        int r;
        r = $urandom_range(0, 99);
        if (reads_ok && r < 45)
            put_word(CMD_READ, 1'($urandom), 8'($urandom));
        else if (flush_ok && r < 50)
            put_word(CMD_FLUSH, 1'($urandom), 8'($urandom));
        else
            put_word(CMD_SEND, 1'($urandom), 8'($urandom));
    endtask

    // Idle ticks, then one 8N1 frame on the receive line at 3 ticks per bit;
    // now and then cut short, glitched, or with a low stop bit
    task automatic rx_frame(input bit reads_ok, input bit flush_ok);
        logic [9:0] line_bits;
        int cut;
        int glitch;
        logic lvl;
        line_bits = {1'b1, 8'($urandom), 1'b0};
        cut       = 10;
        glitch    = -1;
        case ($urandom_range(0, 19))
            0: cut = $urandom_range(1, 9);
            1: glitch = $urandom_range(0, 29);
            2: line_bits[9] = 1'b0;
            default: ;
        endcase
        no_gap = ($urandom_range(0, 3) == 0);
        repeat ($urandom_range(1, 3))
            put_word(CMD_TICK, 1'b1, 8'($urandom));
        for (int t = 0; t < cut * 3; t++) begin
            lvl = line_bits[t / 3] ^ (t == glitch);
            if ($urandom_range(0, 99) < 8)
                host_word(reads_ok, flush_ok);
            put_word(CMD_TICK, lvl, 8'($urandom));
        end
    endtask

    // Result checker
    always @(posedge i_clk) begin : check_results
        uart_status_t got;
        uart_status_t want;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            results_seen++;
            got = m_axis_tdata[12:0];
            if (status_due.size() == 0) begin
                note_failure($sformatf("result %0d arrived with nothing expected", results_seen));
            end else begin
                want = status_due.pop_front();
                if (got.tx_pin !== want.tx_pin)
                    note_failure($sformatf("result %0d tx_pin %b, want %b",
                                           results_seen, got.tx_pin, want.tx_pin));
                if (got.tx_busy !== want.tx_busy)
                    note_failure($sformatf("result %0d tx_busy %b, want %b",
                                           results_seen, got.tx_busy, want.tx_busy));
                if (got.send_accepted !== want.send_accepted)
                    note_failure($sformatf("result %0d send_accepted %b, want %b",
                                           results_seen, got.send_accepted, want.send_accepted));
                if (got.rx_byte !== want.rx_byte)
                    note_failure($sformatf("result %0d rx_byte %h, want %h",
                                           results_seen, got.rx_byte, want.rx_byte));
                if (got.rx_byte_valid !== want.rx_byte_valid)
                    note_failure($sformatf("result %0d rx_byte_valid %b, want %b",
                                           results_seen, got.rx_byte_valid, want.rx_byte_valid));
                if (got.data_available !== want.data_available)
                    note_failure($sformatf("result %0d data_available %b, want %b",
                                           results_seen, got.data_available,
                                           want.data_available));
            end
        end
    end

    // Result sink: random stalls, calm stretches, one long hold-off
    initial begin : result_sink
        int  stall_left;
        bit  calm;
        bit  long_hold_done;
        stall_left     = 0;
        calm           = 1'b0;
        long_hold_done = 1'b0;
        m_axis_tready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (!long_hold_done && results_seen >= 300) begin
                long_hold_done = 1'b1;
                m_axis_tready <= 1'b0;
                repeat (300) @(posedge i_clk);
            end
            if ($urandom_range(0, 199) == 0)
                calm = !calm;
            if (stall_left > 0) begin
                m_axis_tready <= 1'b0;
                stall_left--;
            end else begin
                m_axis_tready <= 1'b1;
                if (!calm && $urandom_range(0, 99) < 20)
                    stall_left = pick_gap();
            end
        end
    end

    // Run limit
    initial begin
        #6_000_000;
        $display("Verification failed");
        $finish;
    end

    // Stimulus
    initial begin : stimulus
        i_rst_n       <= 1'b0;
        s_axis_tvalid <= 1'b0;
        s_axis_tdata  <= '0;
        s_axis_tuser  <= CMD_TICK;
        i_cfg_valid   <= 1'b0;
        i_cfg_data    <= 1'b0;

        rx_enabled   = 1'b1;
        tx_run       = 1'b0;
        tx_phase     = '0;
        tx_left      = '0;
        tx_sr        = '0;
        tx_line      = 1'b1;
        rx_run       = 1'b0;
        rx_stop_wait = 1'b0;
        rx_phase     = '0;
        rx_left      = '0;
        rx_sr        = '0;
        rx_mask      = '0;
        wr_ptr       = '0;
        rd_ptr       = '0;

        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed table
        write_rx_enable(1'b1);
        for (int i = 0; i < DIR_ROWS; i++)
            put_word(DIRECTED[i].cmd, DIRECTED[i].pin, DIRECTED[i].data,
                     DIRECTED[i].typed, DIRECTED[i].want);

        // fill past the FIFO size with no reads so the write index laps
        for (int f = 0; f < 34; f++)
            rx_frame(1'b0, 1'b0);
        no_gap = 1'b0;
        repeat (36)
            put_word(CMD_READ, 1'($urandom), 8'($urandom));

        // receiver frozen: random commands of every kind
        write_rx_enable(1'b0);
        repeat (40)
            put_word(t_cmd'($urandom_range(0, 3)), 1'($urandom), 8'($urandom));

        // receiver back on: frames mixed with reads, sends, flushes and noise
        write_rx_enable(1'b1);
        for (int f = 0; f < 4; f++) begin
            rx_frame(1'b1, 1'b1);
            repeat ($urandom_range(0, 4))
                put_word(t_cmd'($urandom_range(0, 3)), 1'($urandom), 8'($urandom));
        end
        no_gap = 1'b0;
        repeat (12)
            put_word(CMD_READ, 1'($urandom), 8'($urandom));

        // drain and finish
        s_axis_tvalid <= 1'b0;
        while (status_due.size() != 0)
            @(posedge i_clk);
        repeat (8) @(posedge i_clk);
        if (fail_count == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule
